@@ hw/rtl/pcv_pkg.sv @@
// shared types, constants and helper functions for the polar/cartesian vector unit
// no dependencies; the sqrt, cordic and core rtl files import this package
package pcv_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CW = 48;
    localparam int ZW = 34;
    localparam logic [31:0] GAIN_INV = 32'h9B74EDA8;
    localparam logic [31:0] HALF_TURN = 32'h80000000;

    typedef enum logic [3:0] {
        ACT_SETXY    = 4'd0,
        ACT_SETPOLAR = 4'd1,
        ACT_SETX     = 4'd2,
        ACT_SETY     = 4'd3,
        ACT_SETMAG   = 4'd4,
        ACT_SETANGLE = 4'd5,
        ACT_ADD      = 4'd6,
        ACT_SUB      = 4'd7,
        ACT_SCALE    = 4'd8,
        ACT_DOT      = 4'd9,
        ACT_EQUAL    = 4'd10
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCL0,
        ST_SCL1,
        ST_SCL2,
        ST_SQ0,
        ST_SQ1,
        ST_SQ2,
        ST_ITER,
        ST_VFIN,
        ST_GAIN0,
        ST_GAIN1,
        ST_ROT,
        ST_RFIN,
        ST_DOT0,
        ST_DOT1,
        ST_DOT2
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic vec_mode;
    } cordic_ctl_t;

    typedef struct packed {
        logic load;
        logic step;
    } sqrt_ctl_t;

    function automatic logic [31:0] atan_val(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'h20000000;
            5'd1:  r = 32'h12E4051D;
            5'd2:  r = 32'h09FB385B;
            5'd3:  r = 32'h051111D4;
            5'd4:  r = 32'h028B0D43;
            5'd5:  r = 32'h0145D7E1;
            5'd6:  r = 32'h00A2F61E;
            5'd7:  r = 32'h00517C55;
            5'd8:  r = 32'h0028BE53;
            5'd9:  r = 32'h00145F2F;
            5'd10: r = 32'h000A2F98;
            5'd11: r = 32'h000517CC;
            5'd12: r = 32'h00028BE6;
            5'd13: r = 32'h000145F3;
            5'd14: r = 32'h0000A2F9;
            5'd15: r = 32'h0000517C;
            5'd16: r = 32'h000028BE;
            5'd17: r = 32'h0000145F;
            5'd18: r = 32'h00000A2F;
            5'd19: r = 32'h00000517;
            5'd20: r = 32'h0000028B;
            5'd21: r = 32'h00000145;
            5'd22: r = 32'h000000A2;
            5'd23: r = 32'h00000051;
            5'd24: r = 32'h00000028;
            5'd25: r = 32'h00000014;
            5'd26: r = 32'h0000000A;
            5'd27: r = 32'h00000005;
            5'd28: r = 32'h00000002;
            5'd29: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

    // clamp a wide signed value to the int32 range
    function automatic logic signed [31:0] sat32(input logic signed [66:0] v);
        logic signed [31:0] r;
        if (v > 67'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -67'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/pcv_if.sv @@
// request and response channel interfaces of the vector unit
// plain valid/ready handshake, no package dependency
interface pcv_req_if;
    logic               valid;
    logic               ready;
    logic [3:0]         action;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
    logic               store;

    modport source (output valid, action, operand_a, operand_b, store, input ready);
    modport sink (input valid, action, operand_a, operand_b, store, output ready);
endinterface

interface pcv_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic [31:0]        magnitude_out;
    logic signed [31:0] angle_out;
    logic signed [31:0] scalar_out;
    logic               flag;

    modport source (output valid, x_out, y_out, magnitude_out, angle_out, scalar_out, flag,
                    input ready);
    modport sink (input valid, x_out, y_out, magnitude_out, angle_out, scalar_out, flag,
                  output ready);
endinterface

@@ hw/rtl/pcv_mul.sv @@
// shared 33x33 signed multiplier with registered product
// depends on nothing but the clock
module pcv_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

@@ hw/rtl/pcv_sqrt.sv @@
// bit-serial restoring square root of a 64-bit radicand, one root bit per cycle while step is set
// depends on pcv_pkg for the control struct
module pcv_sqrt (
    input  logic                clk,
    input  pcv_pkg::sqrt_ctl_t  ctl,
    input  logic [63:0]         radicand,
    output logic [31:0]         root
);
    import pcv_pkg::*;

    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [35:0] rem2;
    logic [35:0] trial;
    logic        ge;

    always_comb
    begin
        rem2  = {rem_reg, rad_reg[63:62]};
        trial = {2'b00, root_reg, 2'b01};
        ge    = rem2 >= trial;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (ctl.step)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= ge ? 34'(rem2 - trial) : rem2[33:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign root = root_reg;

endmodule

@@ hw/rtl/pcv_cordic.sv @@
// shared cordic stage, one micro-rotation per cycle while step is set, vectoring or rotation mode
// depends on pcv_pkg for widths, the arctangent table and the control struct
module pcv_cordic (
    input  logic                    clk,
    input  pcv_pkg::cordic_ctl_t    ctl,
    input  logic [4:0]              idx,
    input  logic signed [pcv_pkg::CW-1:0] x_init,
    input  logic signed [pcv_pkg::CW-1:0] y_init,
    input  logic signed [pcv_pkg::ZW-1:0] z_init,
    output logic signed [pcv_pkg::CW-1:0] x_q,
    output logic signed [pcv_pkg::CW-1:0] y_q,
    output logic signed [pcv_pkg::ZW-1:0] z_q
);
    import pcv_pkg::*;

    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [ZW-1:0] z_reg;
    logic                 vec_reg;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [ZW-1:0] at;
    logic                 plus;

    always_comb
    begin
        dx   = y_reg >>> idx;
        dy   = x_reg >>> idx;
        at   = {2'b00, atan_val(idx)};
        // same direction: y non-negative when vectoring, angle negative when rotating
        plus = vec_reg ? !y_reg[CW-1] : z_reg[ZW-1];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg   <= x_init;
            y_reg   <= y_init;
            z_reg   <= z_init;
            vec_reg <= ctl.vec_mode;
        end
        else if (ctl.step)
        begin
            if (plus)
            begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + at;
            end
            else
            begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - at;
            end
        end
    end

    assign x_q = x_reg;
    assign y_q = y_reg;
    assign z_q = z_reg;

endmodule

@@ hw/rtl/polar_cartesian_vector_unit_core.sv @@
// vector unit: cartesian writes take 2 squares and 32 root bits (scale multiplies first)
// polar writes run CORDIC_STEPS steps of the shared cordic stage; dot takes two products
// compare, refused and ignored requests answer in the cycle after acceptance
// one request at a time; the next is taken as the finished response is taken
// rst_n clears vector state to zero asynchronously; the sequencer returns to idle
module polar_cartesian_vector_unit_core (
    input  logic      clk,
    input  logic      rst_n,
    pcv_req_if.sink   req,
    pcv_rsp_if.source rsp
);
    import pcv_pkg::*;

    state_t             state_reg, state_next;
    logic [4:0]         cnt_reg;
    logic [3:0]         act_reg;
    logic signed [31:0] a_reg, b_reg;
    logic               store_reg;
    logic signed [31:0] x_coord_reg, y_coord_reg;
    logic [31:0]        length_reg, direction_reg;
    logic signed [31:0] rx_reg, ry_reg;
    logic [63:0]        sq_reg;
    logic signed [65:0] dp_reg;
    logic               neg_reg;
    logic signed [31:0] xo_reg, yo_reg, ao_reg, so_reg;
    logic [31:0]        mo_reg;
    logic               fo_reg;
    logic               out_valid_reg;

    logic               acc;
    logic               finish;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;
    logic [31:0]        root;
    cordic_ctl_t        cctl;
    sqrt_ctl_t          sctl;
    logic signed [CW-1:0] cx_init, cy_init, cx_q, cy_q;
    logic signed [ZW-1:0] cz_init, cz_q;
    logic signed [CW-1:0] xe, ye, xs, ys;
    logic signed [CW-1:0] xr, yr;
    logic [31:0]        zf;
    logic               fold;
    logic signed [66:0] dsum;
    logic               cart_commit;

    pcv_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    pcv_sqrt u_sqrt (
        .clk      (clk),
        .ctl      (sctl),
        .radicand (sq_reg + prod[63:0]),
        .root     (root)
    );

    pcv_cordic u_cordic (
        .clk    (clk),
        .ctl    (cctl),
        .idx    (cnt_reg),
        .x_init (cx_init),
        .y_init (cy_init),
        .z_init (cz_init),
        .x_q    (cx_q),
        .y_q    (cy_q),
        .z_q    (cz_q)
    );

    assign acc = req.valid && req.ready;

    // cordic start values and final scaling
    always_comb
    begin
        xe   = {{8{rx_reg[31]}}, rx_reg, 8'h00};
        ye   = {{8{ry_reg[31]}}, ry_reg, 8'h00};
        fold = direction_reg[31] ^ direction_reg[30];
        zf   = direction_reg + (fold ? HALF_TURN : 32'h0);
        xs   = neg_reg ? -cx_q : cx_q;
        ys   = neg_reg ? -cy_q : cy_q;
        xr   = (xs + CW'(128)) >>> 8;
        yr   = (ys + CW'(128)) >>> 8;
        dsum = {prod[65], prod} + {dp_reg[65], dp_reg};
        cart_commit = store_reg || act_reg == ACT_SETXY || act_reg == ACT_SETX
                      || act_reg == ACT_SETY;
    end

    // sequencer: next state and unit controls
    always_comb
    begin
        state_next = state_reg;
        finish     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        cctl       = '0;
        sctl       = '0;
        cx_init    = '0;
        cy_init    = '0;
        cz_init    = '0;
        req.ready  = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
        unique case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    case (action_t'(req.action))
                        ACT_SETXY, ACT_SETX, ACT_SETY, ACT_ADD, ACT_SUB:
                            state_next = ST_SQ0;
                        ACT_SETPOLAR:
                            state_next = ST_GAIN0;
                        ACT_SETMAG, ACT_SETANGLE:
                        begin
                            if (length_reg != '0)
                                state_next = ST_GAIN0;
                            else
                                finish = 1'b1;
                        end
                        ACT_SCALE:
                            state_next = ST_SCL0;
                        ACT_DOT:
                            state_next = ST_DOT0;
                        default:
                            finish = 1'b1;
                    endcase
                end
            end
            ST_SCL0:
            begin
                mul_a      = {x_coord_reg[31], x_coord_reg};
                mul_b      = {a_reg[31], a_reg};
                state_next = ST_SCL1;
            end
            ST_SCL1:
            begin
                mul_a      = {y_coord_reg[31], y_coord_reg};
                mul_b      = {a_reg[31], a_reg};
                state_next = ST_SCL2;
            end
            ST_SCL2:
                state_next = ST_SQ0;
            ST_SQ0:
            begin
                mul_a      = {rx_reg[31], rx_reg};
                mul_b      = {rx_reg[31], rx_reg};
                state_next = ST_SQ1;
            end
            ST_SQ1:
            begin
                mul_a      = {ry_reg[31], ry_reg};
                mul_b      = {ry_reg[31], ry_reg};
                state_next = ST_SQ2;
            end
            ST_SQ2:
            begin
                sctl.load     = 1'b1;
                cctl.load     = 1'b1;
                cctl.vec_mode = 1'b1;
                // pre-rotate by half a turn when x is negative
                cx_init       = rx_reg[31] ? -xe : xe;
                cy_init       = rx_reg[31] ? -ye : ye;
                cz_init       = rx_reg[31] ? {2'b00, HALF_TURN} : '0;
                state_next    = ST_ITER;
            end
            ST_ITER:
            begin
                sctl.step = 1'b1;
                cctl.step = {1'b0, cnt_reg} < 6'(CORDIC_STEPS);
                if (cnt_reg == 5'd31)
                    state_next = ST_VFIN;
            end
            ST_VFIN:
            begin
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_GAIN0:
            begin
                mul_a      = {1'b0, length_reg};
                mul_b      = {1'b0, GAIN_INV};
                state_next = ST_GAIN1;
            end
            ST_GAIN1:
            begin
                cctl.load  = 1'b1;
                cx_init    = {8'h00, prod[63:24]};
                cy_init    = '0;
                cz_init    = {{2{zf[31]}}, zf};
                state_next = ST_ROT;
            end
            ST_ROT:
            begin
                cctl.step = 1'b1;
                if (cnt_reg == 5'(CORDIC_STEPS - 1))
                    state_next = ST_RFIN;
            end
            ST_RFIN:
            begin
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            ST_DOT0:
            begin
                mul_a      = {x_coord_reg[31], x_coord_reg};
                mul_b      = {a_reg[31], a_reg};
                state_next = ST_DOT1;
            end
            ST_DOT1:
            begin
                mul_a      = {y_coord_reg[31], y_coord_reg};
                mul_b      = {b_reg[31], b_reg};
                state_next = ST_DOT2;
            end
            ST_DOT2:
            begin
                finish     = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // control registers: vector state, step counter, response valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            x_coord_reg   <= '0;
            y_coord_reg   <= '0;
            length_reg    <= '0;
            direction_reg <= '0;
        end
        else
        begin
            if (state_reg == ST_SQ2 || state_reg == ST_GAIN1)
                cnt_reg <= '0;
            else if (state_reg == ST_ITER || state_reg == ST_ROT)
                cnt_reg <= cnt_reg + 5'd1;

            if (finish)
                out_valid_reg <= 1'b1;
            else if (rsp.ready)
                out_valid_reg <= 1'b0;

            if (acc)
            begin
                case (action_t'(req.action))
                    ACT_SETXY:
                    begin
                        x_coord_reg <= req.operand_a;
                        y_coord_reg <= req.operand_b;
                    end
                    ACT_SETPOLAR:
                    begin
                        length_reg    <= req.operand_a[31] ? 32'(-req.operand_a)
                                                           : req.operand_a;
                        direction_reg <= req.operand_b
                                         + (req.operand_a[31] ? HALF_TURN : 32'h0);
                    end
                    ACT_SETX:
                        x_coord_reg <= req.operand_a;
                    ACT_SETY:
                        y_coord_reg <= req.operand_a;
                    ACT_SETMAG:
                    begin
                        if (length_reg != '0)
                        begin
                            length_reg <= req.operand_a[31] ? 32'(-req.operand_a)
                                                            : req.operand_a;
                            if (req.operand_a[31])
                                direction_reg <= direction_reg + HALF_TURN;
                        end
                    end
                    ACT_SETANGLE:
                    begin
                        if (length_reg != '0)
                            direction_reg <= req.operand_a;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (state_reg == ST_VFIN && cart_commit)
            begin
                x_coord_reg   <= rx_reg;
                y_coord_reg   <= ry_reg;
                length_reg    <= root;
                direction_reg <= (rx_reg == '0 && ry_reg == '0) ? '0 : cz_q[31:0];
            end

            if (state_reg == ST_RFIN)
            begin
                x_coord_reg <= sat32(67'(xr));
                y_coord_reg <= sat32(67'(yr));
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            act_reg   <= req.action;
            a_reg     <= req.operand_a;
            b_reg     <= req.operand_b;
            store_reg <= req.store;
            case (action_t'(req.action))
                ACT_SETXY:
                begin
                    rx_reg <= req.operand_a;
                    ry_reg <= req.operand_b;
                end
                ACT_SETX:
                begin
                    rx_reg <= req.operand_a;
                    ry_reg <= y_coord_reg;
                end
                ACT_SETY:
                begin
                    rx_reg <= x_coord_reg;
                    ry_reg <= req.operand_a;
                end
                ACT_ADD:
                begin
                    rx_reg <= sat32(67'(x_coord_reg) + 67'(req.operand_a));
                    ry_reg <= sat32(67'(y_coord_reg) + 67'(req.operand_b));
                end
                ACT_SUB:
                begin
                    rx_reg <= sat32(67'(x_coord_reg) - 67'(req.operand_a));
                    ry_reg <= sat32(67'(y_coord_reg) - 67'(req.operand_b));
                end
                default:
                begin
                end
            endcase
            // requests answered at once show the unchanged state
            xo_reg <= x_coord_reg;
            yo_reg <= y_coord_reg;
            mo_reg <= length_reg;
            ao_reg <= direction_reg;
            so_reg <= '0;
            if (action_t'(req.action) == ACT_EQUAL)
                fo_reg <= (x_coord_reg == req.operand_a) && (y_coord_reg == req.operand_b);
            else if (action_t'(req.action) == ACT_SETMAG)
                fo_reg <= length_reg != '0;
            else
                fo_reg <= 1'b1;
        end

        if (state_reg == ST_SCL1)
            rx_reg <= sat32(67'(prod >>> 16));
        if (state_reg == ST_SCL2)
            ry_reg <= sat32(67'(prod >>> 16));
        if (state_reg == ST_SQ1)
            sq_reg <= prod[63:0];
        if (state_reg == ST_DOT1)
            dp_reg <= prod;
        if (state_reg == ST_GAIN1)
            neg_reg <= fold;

        if (state_reg == ST_VFIN)
        begin
            xo_reg <= rx_reg;
            yo_reg <= ry_reg;
            mo_reg <= root;
            ao_reg <= (rx_reg == '0 && ry_reg == '0) ? '0 : cz_q[31:0];
            so_reg <= '0;
            fo_reg <= 1'b1;
        end

        if (state_reg == ST_RFIN)
        begin
            xo_reg <= sat32(67'(xr));
            yo_reg <= sat32(67'(yr));
            mo_reg <= length_reg;
            ao_reg <= direction_reg;
            so_reg <= '0;
            fo_reg <= 1'b1;
        end

        if (state_reg == ST_DOT2)
        begin
            xo_reg <= x_coord_reg;
            yo_reg <= y_coord_reg;
            mo_reg <= length_reg;
            ao_reg <= direction_reg;
            so_reg <= sat32(dsum >>> 16);
            fo_reg <= 1'b1;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.x_out         = xo_reg;
    assign rsp.y_out         = yo_reg;
    assign rsp.magnitude_out = mo_reg;
    assign rsp.angle_out     = ao_reg;
    assign rsp.scalar_out    = so_reg;
    assign rsp.flag          = fo_reg;

`ifndef SYNTH
    a_busy_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !out_valid_reg)
        else $error("response pending while a request is in progress");

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |-> state_reg == ST_IDLE)
        else $error("request accepted while busy");

    a_rot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ROT |-> {1'b0, cnt_reg} < 6'(CORDIC_STEPS))
        else $error("rotation ran past its step count");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_VFIN |=> out_valid_reg && state_reg == ST_IDLE)
        else $error("vector result not presented");
`endif

endmodule

@@ tb/pcv_tb_if.sv @@
// testbench support file; holds no declarations of its own
// the testbench instantiates pcv_req_if and pcv_rsp_if from hw/rtl/pcv_if.sv

@@ tb/tb_polar_cartesian_vector_unit_core.sv @@
// testbench for polar_cartesian_vector_unit_core: random and directed requests,
// built-in predictor and scoreboard; depends on pcv_pkg and pcv_if from the rtl
module tb_polar_cartesian_vector_unit_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pcv_pkg::*;

    localparam int WATCHDOG = 20000;
    localparam logic [31:0] GAIN_K = 32'h9B74EDA8;
    localparam logic [31:0] HALFT = 32'h80000000;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        mag;
        logic [31:0]        ang;
        logic signed [31:0] dotv;
        logic               flag;
    } vec_result_t;

    int errors = 0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    function automatic logic [31:0] arctan_step(input int i);
        logic [31:0] t [0:31];
        t = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
              32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
              32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
              32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
              32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
              32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
              32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
              32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};
        return t[i];
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic [31:0] root64(input logic [63:0] v);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] length_of(input logic signed [31:0] x,
                                                input logic signed [31:0] y);
        longint xx, yy;
        xx = longint'(x) * longint'(x);
        yy = longint'(y) * longint'(y);
        return root64(64'(xx) + 64'(yy));
    endfunction

    function automatic logic [31:0] bearing_of(input logic signed [31:0] x,
                                                 input logic signed [31:0] y);
        longint bx, by, dx, dy;
        logic [31:0] z;
        if (x == 0 && y == 0) return 0;
        bx = longint'(x) * 256;
        by = longint'(y) * 256;
        z = 0;
        if (bx < 0) begin
            bx = -bx;
            by = -by;
            z = HALFT;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = by >>> i;
            dy = bx >>> i;
            if (by < 0) begin
                bx -= dx; by += dy; z -= arctan_step(i);
            end else begin
                bx += dx; by -= dy; z += arctan_step(i);
            end
        end
        return z;
    endfunction

    task automatic rotate_out(input logic [31:0] len, input logic [31:0] dir,
                              output logic signed [31:0] xo, output logic signed [31:0] yo);
        logic [31:0] z;
        logic [63:0] prod;
        bit flip;
        longint zz, rx, ry, dx, dy;
        z = dir;
        flip = (dir[31:30] == 2'd1 || dir[31:30] == 2'd2);
        if (flip) z = z + HALFT;
        zz = longint'(signed'(z));
        prod = 64'(len) * 64'(GAIN_K);
        rx = longint'(prod >> 24);
        ry = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = ry >>> i;
            dy = rx >>> i;
            if (zz >= 0) begin
                rx -= dx; ry += dy; zz -= longint'(arctan_step(i));
            end else begin
                rx += dx; ry -= dy; zz += longint'(arctan_step(i));
            end
        end
        if (flip) begin
            rx = -rx;
            ry = -ry;
        end
        xo = clamp32((rx + 128) >>> 8);
        yo = clamp32((ry + 128) >>> 8);
    endtask

    class vector_scoreboard;
        logic signed [31:0] vx, vy;
        logic [31:0] vlen, vdir;
        vec_result_t pending[$];
        int checked;

        function new();
            vx = 0; vy = 0; vlen = 0; vdir = 0; checked = 0;
        endfunction

        task note_request(input logic [3:0] act, input logic signed [31:0] a,
                          input logic signed [31:0] b, input logic st);
            vec_result_t r;
            logic signed [31:0] rx, ry;
            longint p1, p2, hi, lo;
            bit keep;
            keep = 1;
            r.dotv = 0;
            r.flag = 1;
            case (act)
                ACT_SETXY: begin
                    vx = a; vy = b; vlen = length_of(vx, vy); vdir = bearing_of(vx, vy);
                end
                ACT_SETPOLAR: begin
                    if (a < 0) begin
                        vlen = 32'(-longint'(a)); vdir = b + HALFT;
                    end else begin
                        vlen = a; vdir = b;
                    end
                    rotate_out(vlen, vdir, vx, vy);
                end
                ACT_SETX: begin
                    vx = a; vlen = length_of(vx, vy); vdir = bearing_of(vx, vy);
                end
                ACT_SETY: begin
                    vy = a; vlen = length_of(vx, vy); vdir = bearing_of(vx, vy);
                end
                ACT_SETMAG: begin
                    if (vlen == 0) r.flag = 0;
                    else begin
                        if (a < 0) begin
                            vdir += HALFT; vlen = 32'(-longint'(a));
                        end else vlen = a;
                        rotate_out(vlen, vdir, vx, vy);
                    end
                end
                ACT_SETANGLE: begin
                    if (vlen != 0) begin
                        vdir = a; rotate_out(vlen, vdir, vx, vy);
                    end
                end
                ACT_ADD, ACT_SUB, ACT_SCALE: begin
                    if (act == ACT_ADD) begin
                        rx = clamp32(longint'(vx) + a); ry = clamp32(longint'(vy) + b);
                    end else if (act == ACT_SUB) begin
                        rx = clamp32(longint'(vx) - a); ry = clamp32(longint'(vy) - b);
                    end else begin
                        rx = clamp32((longint'(vx) * a) >>> 16);
                        ry = clamp32((longint'(vy) * a) >>> 16);
                    end
                    r.x = rx; r.y = ry;
                    r.mag = length_of(rx, ry); r.ang = bearing_of(rx, ry);
                    if (st) begin
                        vx = rx; vy = ry; vlen = r.mag; vdir = r.ang;
                    end else keep = 0;
                end
                ACT_DOT: begin
                    p1 = longint'(vx) * a;
                    p2 = longint'(vy) * b;
                    hi = (p1 >>> 16) + (p2 >>> 16);
                    lo = ((p1 & 64'hFFFF) + (p2 & 64'hFFFF)) >>> 16;
                    r.dotv = clamp32(hi + lo);
                end
                ACT_EQUAL: r.flag = (vx == a && vy == b);
                default: ;
            endcase
            if (keep) begin
                r.x = vx; r.y = vy; r.mag = vlen; r.ang = vdir;
            end
            pending.push_back(r);
        endtask

        task check_result(input logic signed [31:0] x, input logic signed [31:0] y,
                          input logic [31:0] m, input logic [31:0] ang,
                          input logic signed [31:0] d, input logic f);
            vec_result_t w;
            if (pending.size() == 0) begin
                report("unexpected response", 0, 0);
                return;
            end
            w = pending.pop_front();
            checked++;
            if (x !== w.x) report("x_out", x, w.x);
            if (y !== w.y) report("y_out", y, w.y);
            if (m !== w.mag) report("magnitude_out", m, w.mag);
            if (ang !== w.ang) report("angle_out", ang, w.ang);
            if (d !== w.dotv) report("scalar_out", d, w.dotv);
            if (f !== w.flag) report("flag", 32'(f), 32'(w.flag));
        endtask
    endclass

    logic clk = 0;
    logic rst_n = 0;
    pcv_req_if req();
    pcv_rsp_if rsp();
    vector_scoreboard board;

    polar_cartesian_vector_unit_core uut (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

    always
    begin
        #10 clk = 1;
        #10 clk = 0;
    end

    int send_idle_pct = 13;
    int recv_idle_pct = 60;
    int holdoff = 0;
    int quiet = 0;
    int sent = 0;
    int act_seen[16];

    initial
    begin
        req.valid = 0; req.action = 0; req.operand_a = 0; req.operand_b = 0; req.store = 0;
        rsp.ready = 0;
    end

    // response side: random stall, plus a long hold-off when requested
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (rsp.valid && rsp.ready)
                board.check_result(rsp.x_out, rsp.y_out, rsp.magnitude_out, rsp.angle_out,
                                   rsp.scalar_out, rsp.flag);
            if (holdoff > 0) begin
                holdoff <= holdoff - 1;
                rsp.ready <= 0;
            end else
                rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet > WATCHDOG) begin
            $display("watchdog expired, no traffic for %0d cycles", WATCHDOG);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send(input logic [3:0] act, input logic signed [31:0] a,
                        input logic signed [31:0] b, input logic st);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 0;
            @(posedge clk);
        end
        req.valid <= 1; req.action <= act; req.operand_a <= a; req.operand_b <= b;
        req.store <= st;
        @(posedge clk);
        while (!req.ready) @(posedge clk);
        board.note_request(act, a, b, st);
        act_seen[act]++;
        sent++;
    endtask

    function automatic logic signed [31:0] pick_val();
        case ($urandom_range(5))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return $urandom_range(0, 1) ? $urandom_range(0, 32'h00FFFFFF)
                                           : -$urandom_range(0, 32'h00FFFFFF);
            3: return $urandom_range(0, 32'h7FFFF) - 32'h3FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_part(input int n);
        logic [3:0] act;
        for (int i = 0; i < n; i++) begin
            act = ($urandom_range(40) == 0) ? 4'($urandom_range(11, 15))
                                            : 4'($urandom_range(0, 10));
            if (act == ACT_EQUAL && $urandom_range(1))
                send(act, board.vx, board.vy, 1'($urandom_range(1)));
            else if (act == ACT_SCALE)
                send(act, $urandom_range(1) ? pick_val()
                     : 32'($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF, pick_val(),
                     1'($urandom_range(1)));
            else
                send(act, pick_val(), pick_val(), 1'($urandom_range(1)));
        end
        req.valid <= 0;
    endtask

    task automatic drain();
        while (board.pending.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    initial
    begin
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        // directed: refused and ignored polar writes at zero length, extremes, every action
        send(ACT_SETMAG, 32'sd65536, 0, 0);
        send(ACT_SETANGLE, 32'sh40000000, 0, 0);
        send(ACT_EQUAL, 0, 0, 0);
        send(ACT_SETXY, 32'sh7FFFFFFF, 32'sh80000000, 0);
        send(ACT_SETXY, 32'sh80000000, 32'sh80000000, 0);
        send(ACT_SETXY, -32'sd65536, 0, 0);
        send(ACT_SETX, 0, 0, 0);
        send(ACT_SETY, 32'sd65536, 0, 0);
        send(ACT_SETPOLAR, 32'sh80000000, 32'sh40000000, 0);
        send(ACT_SETPOLAR, 32'sh7FFFFFFF, 32'shC0000000, 1);
        send(ACT_SETMAG, -32'sd131072, 0, 0);
        send(ACT_SETANGLE, 32'sh80000000, 0, 0);
        send(ACT_ADD, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0);
        send(ACT_SUB, 32'sh7FFFFFFF, 32'sh80000000, 1);
        send(ACT_SCALE, 32'sh7FFFFFFF, 0, 0);
        send(ACT_SCALE, -32'sd32768, 0, 1);
        send(ACT_DOT, 32'sh7FFFFFFF, 32'sh80000000, 0);
        send(ACT_DOT, 32'sh80000000, 32'sh80000000, 0);
        send(ACT_EQUAL, 32'sh7FFFFFFF, 0, 0);
        send(4'd15, -1, -1, 1);
        send(ACT_SETXY, 0, 0, 0);
        send(ACT_SCALE, 32'sd65536, 0, 1);
        req.valid <= 0;
        drain();

        random_part(600);
        send_idle_pct = 60;
        recv_idle_pct = 13;
        random_part(600);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        holdoff = 300;
        random_part(650);
        drain();

        $display("%0d requests sent, %0d responses checked; setmag %0d, dot %0d, unused codes %0d",
                 sent, board.checked, act_seen[ACT_SETMAG], act_seen[ACT_DOT],
                 act_seen[11] + act_seen[12] + act_seen[13] + act_seen[14] + act_seen[15]);
        if (errors == 0 && board.pending.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
